// ===== rtl/core/sorted_table_binary_search_top_macros.svh =====
// Assertion macros shared by the sorted table search RTL.
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define STBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define STBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/stbs_pkg.sv =====
// Package with the types and constants of the sorted table search block.
package stbs_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int DEFAULT_KEY_WIDTH   = 32;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_HIT  = 2'd0,
        ST_HEAD = 2'd1,
        ST_MISS = 2'd2,
        ST_TAIL = 2'd3
    } status_t;

endpackage

// ===== rtl/core/sorted_table_binary_search_top.sv =====
// Sorted key table with a binary search that reports a hit or the insertion point.

// The table sits in one synchronous memory with one write port and one registered read port.
// A write transfer stores one key. A search transfer probes the first entry, then the last
// entry, and then bisects; every probe is one memory read followed by one compare. An empty
// table answers without a probe, and a key at or beyond either end is answered by the probe
// of that end. A new transfer is taken once the previous search has placed its result in
// the output register, even while that result still waits to be taken.
// There is no clearing pass: entries must be written before a search can reach them.

`include "sorted_table_binary_search_top_macros.svh"

module sorted_table_binary_search_top
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int KEY_WIDTH   = DEFAULT_KEY_WIDTH,
    localparam int IDX_W      = $clog2(TABLE_DEPTH),
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1),
    localparam int IN_W       = ((IDX_W + 2 * KEY_WIDTH + 7) / 8) * 8,
    localparam int OUT_W      = ((2 + CNT_W + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data,      // entry_count

    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,       // entry_index, entry_key, search_key, zero padding
    input  logic             s_tuser,       // req_type

    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata        // status, position, zero padding
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_TAIL,
        S_BIS_ADDR,
        S_BIS_CMP,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [CNT_W-1:0]     lo_reg;
    logic [CNT_W-1:0]     hi_reg;
    logic [IDX_W-1:0]     mid_reg;
    status_t              res_status_reg;
    logic [CNT_W-1:0]     res_pos_reg;
    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_data_reg;

    logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0] rd_data_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     mid;
    logic [CNT_W-1:0]     last_idx;

    logic                 in_xfer;
    logic [IDX_W-1:0]     entry_index;
    logic [KEY_WIDTH-1:0] entry_key;
    logic [KEY_WIDTH-1:0] search_key;

    assign entry_index = s_tdata[IDX_W-1:0];
    assign entry_key   = s_tdata[IDX_W +: KEY_WIDTH];
    assign search_key  = s_tdata[IDX_W + KEY_WIDTH +: KEY_WIDTH];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign last_idx = count_reg - CNT_W'(1);
    assign mid      = IDX_W'(lo_reg + ((hi_reg - lo_reg) >> 1));

    always_comb
    begin
        case (state_reg)
            S_HEAD:     rd_addr = last_idx[IDX_W-1:0];
            S_BIS_ADDR: rd_addr = mid;
            default:    rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && (s_tuser == REQ_WRITE) && (32'(entry_index) < 32'(TABLE_DEPTH)))
        begin
            mem[entry_index] <= entry_key;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_data > CNT_W'(TABLE_DEPTH))
                begin
                    count_reg <= CNT_W'(TABLE_DEPTH);
                end
                else
                begin
                    count_reg <= cfg_data;
                end
            end

            if (out_valid_reg && m_tready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer && (s_tuser == REQ_SEARCH))
                    begin
                        key_reg <= search_key;
                        if (count_reg == '0)
                        begin
                            res_status_reg <= ST_TAIL;
                            res_pos_reg    <= '0;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_HEAD;
                        end
                    end
                end
                S_HEAD:
                begin
                    if (key_reg < rd_data_reg)
                    begin
                        res_status_reg <= ST_HEAD;
                        res_pos_reg    <= '0;
                        state_reg      <= S_DONE;
                    end
                    else if (key_reg == rd_data_reg)
                    begin
                        res_status_reg <= ST_HIT;
                        res_pos_reg    <= '0;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_TAIL;
                    end
                end
                S_TAIL:
                begin
                    if (key_reg > rd_data_reg)
                    begin
                        res_status_reg <= ST_TAIL;
                        res_pos_reg    <= count_reg;
                        state_reg      <= S_DONE;
                    end
                    else if (key_reg == rd_data_reg)
                    begin
                        res_status_reg <= ST_HIT;
                        res_pos_reg    <= last_idx;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        lo_reg    <= '0;
                        hi_reg    <= last_idx;
                        state_reg <= S_BIS_ADDR;
                    end
                end
                S_BIS_ADDR:
                begin
                    if (hi_reg >= lo_reg)
                    begin
                        mid_reg   <= mid;
                        state_reg <= S_BIS_CMP;
                    end
                    else
                    begin
                        res_status_reg <= ST_MISS;
                        res_pos_reg    <= lo_reg;
                        state_reg      <= S_DONE;
                    end
                end
                S_BIS_CMP:
                begin
                    if (key_reg == rd_data_reg)
                    begin
                        res_status_reg <= ST_HIT;
                        res_pos_reg    <= CNT_W'(mid_reg);
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        if (key_reg < rd_data_reg)
                        begin
                            hi_reg <= CNT_W'(mid_reg) - CNT_W'(1);
                        end
                        else
                        begin
                            lo_reg <= CNT_W'(mid_reg) + CNT_W'(1);
                        end
                        state_reg <= S_BIS_ADDR;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= OUT_W'({res_pos_reg, res_status_reg});
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `STBS_ASSERT_NEXT(a_search_leaves_idle, in_xfer && (s_tuser == REQ_SEARCH), state_reg != S_IDLE, "search transfer did not start a lookup")
    `STBS_ASSERT_NOW(a_probe_in_range, state_reg == S_BIS_CMP, (CNT_W'(mid_reg) >= lo_reg) && (CNT_W'(mid_reg) <= hi_reg), "bisection probe outside its range")
    `STBS_ASSERT_NOW(a_hi_below_count, (state_reg == S_BIS_ADDR) || (state_reg == S_BIS_CMP), hi_reg < count_reg, "upper bound beyond the table")
    `STBS_ASSERT_NOW(a_head_at_zero, out_valid_reg && (out_data_reg[1:0] == ST_HEAD), out_data_reg[2 +: CNT_W] == '0, "head result with a non-zero position")

endmodule
